// ===== sv/rgp_pkg.sv =====
`default_nettype none

package rgp_pkg;

	// width of the gradient parameter on the output
	localparam int T_OUT_BITS = 24;

	// configuration register index
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_FOCAL_X  = 3'd2,
		REG_FOCAL_Y  = 3'd3,
		REG_RADIUS   = 3'd4
	} reg_idx_t;

	// per-item control flags carried down the pipe
	typedef struct packed {
		logic conc;    // focus sits on the center
		logic transp;  // radius not positive
		logic zero;    // result forced to zero
		logic over;    // quotient does not fit, clip
	} rgp_flags_t;

endpackage

`default_nettype wire

// ===== sv/radial_gradient_parameter_top.sv =====
`default_nettype none

// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tdata: pixel_x, pixel_y
// m_        out  m_tvalid / m_tready       m_tdata: grad_t; m_tuser: transparent, saturated
// cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one pixel per cycle while the output is not stalled; radicand width RW = 100 at defaults
// most of the latency lies in the square root cell row (one root bit per cell) and the divider
// cell row (one quotient bit per cell)
// the whole pipe advances when the output register is empty or taken; a stall holds every stage
// reset clears the valid bits and the configuration registers to zero
module radial_gradient_parameter_top import rgp_pkg::*; #(
	parameter int COORD_BITS  = 24,
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,  // pixel_x, pixel_y
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [T_OUT_BITS-1:0]                    m_tdata,  // grad_t
	output logic [1:0]                               m_tuser,  // transparent, saturated
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [REG_IDX_W-1:0]                cfg_index,
	input  wire logic [COORD_BITS-1:0]               cfg_data
);

	localparam int CW   = COORD_BITS;
	localparam int TF   = T_FRAC_BITS;
	localparam int DXW  = CW + 1;
	localparam int SQW  = 2 * CW + 2;
	localparam int MW   = 2 * SQW;
	localparam int RW   = (4*CW + 4 > 2*CW + 2 + 2*TF) ? 4*CW + 4 : 2*CW + 2 + 2*TF;
	localparam int NQ   = RW / 2;
	localparam int DENW = NQ + 2;
	localparam int DENU = NQ + 1;
	localparam int NUMW = (SQW + TF > NQ) ? SQW + TF : NQ;
	localparam int XW   = ((NUMW > DENU + T_OUT_BITS) ? NUMW : DENU + T_OUT_BITS) + 1;
	localparam int FLW  = $bits(rgp_flags_t);
	localparam int SSW  = SQW + (SQW + 1) + FLW;

	// configuration registers
	logic [CW-1:0] cx_q, cy_q, fx_q, fy_q, r_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			fx_q <= '0;
			fy_q <= '0;
			r_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				REG_FOCAL_X:  fx_q <= cfg_data;
				REG_FOCAL_Y:  fy_q <= cfg_data;
				REG_RADIUS:   r_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: offsets from the focus
	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic                  v_s1;
	logic [CW-1:0]         px, py;

	assign px = s_tdata[CW-1:0];
	assign py = s_tdata[2*CW-1:CW];

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= $signed({px[CW-1], px}) - $signed({fx_q[CW-1], fx_q});
			dy_s1 <= $signed({py[CW-1], py}) - $signed({fy_q[CW-1], fy_q});
		end
	end

	// stage 2: dd, b and c
	logic signed [DXW-1:0]   mx, my;
	logic signed [2*DXW-1:0] pxx, pyy, pbx, pby, pmx, pmy;
	logic signed [2*CW-1:0]  prr;
	logic signed [SQW:0]     b_w, c_w;
	logic [SQW-1:0]          dd_w, bmag_w, cmag_w;
	rgp_flags_t              fl_w;

	assign mx  = $signed({fx_q[CW-1], fx_q}) - $signed({cx_q[CW-1], cx_q});
	assign my  = $signed({fy_q[CW-1], fy_q}) - $signed({cy_q[CW-1], cy_q});
	assign pxx = dx_s1 * dx_s1;
	assign pyy = dy_s1 * dy_s1;
	assign pbx = mx * dx_s1;
	assign pby = my * dy_s1;
	assign pmx = mx * mx;
	assign pmy = my * my;
	assign prr = $signed(r_q) * $signed(r_q);

	assign dd_w   = SQW'(pxx) + SQW'(pyy);
	assign b_w    = (SQW+1)'(pbx) + (SQW+1)'(pby);
	assign c_w    = (SQW+1)'(pmx) + (SQW+1)'(pmy) - (SQW+1)'(prr);
	assign bmag_w = b_w[SQW] ? SQW'(-b_w) : SQW'(b_w);
	assign cmag_w = c_w[SQW] ? SQW'(-c_w) : SQW'(c_w);

	always_comb begin
		fl_w        = '0;
		fl_w.conc   = (fx_q == cx_q) && (fy_q == cy_q);
		fl_w.transp = r_q[CW-1] || (r_q == '0);
	end

	logic [SQW-1:0]    dd_s2, bmag_s2, cmag_s2;
	logic signed [SQW:0] b_s2;
	logic              cneg_s2;
	rgp_flags_t        fl_s2;
	logic              v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s2   <= dd_w;
			b_s2    <= b_w;
			bmag_s2 <= bmag_w;
			cmag_s2 <= cmag_w;
			cneg_s2 <= c_w[SQW];
			fl_s2   <= fl_w;
		end
	end

	// stages 3-4: b*b and dd*|c|
	logic [MW-1:0]          bb_s4, ddc_s4;
	logic [SQW-1:0]         dd_s4;
	logic signed [SQW:0]    b_s4;
	rgp_flags_t             fl_s4;
	logic                   cneg_s4, cneg2_s4;
	logic                   v_s4, v2_s4;

	rgp_wmul #(.W(SQW), .SW(SQW + SQW + 1 + FLW + 1)) u_mul_bb (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_i    (v_s2),
		.a      (bmag_s2),
		.b      (bmag_s2),
		.side_i ({dd_s2, b_s2, fl_s2, cneg_s2}),
		.v_o    (v_s4),
		.p      (bb_s4),
		.side_o ({dd_s4, b_s4, fl_s4, cneg_s4})
	);

	rgp_wmul #(.W(SQW), .SW(1)) u_mul_ddc (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.v_i    (v_s2),
		.a      (dd_s2),
		.b      (cmag_s2),
		.side_i (cneg_s2),
		.v_o    (v2_s4),
		.p      (ddc_s4),
		.side_o (cneg2_s4)
	);

	// stage 5: discriminant and radicand select
	logic [MW:0]     disc_w;
	rgp_flags_t      fl5_w;
	logic [RW-1:0]   rad_w;

	assign disc_w = cneg_s4 ? ({1'b0, bb_s4} + {1'b0, ddc_s4})
	                        : ({1'b0, bb_s4} - {1'b0, ddc_s4});

	always_comb begin
		fl5_w      = fl_s4;
		fl5_w.zero = !fl_s4.conc && ((dd_s4 == '0) || disc_w[MW]);
	end

	assign rad_w = fl_s4.conc ? RW'({dd_s4, {(2*TF){1'b0}}}) : RW'(disc_w[MW-1:0]);

	logic [RW-1:0]       rad_s5;
	logic [SQW-1:0]      dd_s5;
	logic signed [SQW:0] b_s5;
	rgp_flags_t          fl_s5;
	logic                v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s5 <= rad_w;
			dd_s5  <= dd_s4;
			b_s5   <= b_s4;
			fl_s5  <= fl5_w;
		end
	end

	// square root cell row
	logic [NQ+1:0] srem [0:NQ];
	logic [NQ-1:0] sroot [0:NQ];
	logic [RW-1:0] srad [0:NQ];
	logic [SSW-1:0] sside [0:NQ];
	logic [NQ:0]   sv;

	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign srad[0]  = rad_s5;
	assign sside[0] = {dd_s5, b_s5, fl_s5};
	assign sv[0]    = v_s5;

	for (genvar i = 0; i < NQ; i++) begin : g_sqrt
		rgp_sqrt_cell #(.NQ(NQ), .RW(RW), .SW(SSW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.v_i    (sv[i]),
			.rem_i  (srem[i]),
			.root_i (sroot[i]),
			.rad_i  (srad[i]),
			.side_i (sside[i]),
			.v_o    (sv[i+1]),
			.rem_o  (srem[i+1]),
			.root_o (sroot[i+1]),
			.rad_o  (srad[i+1]),
			.side_o (sside[i+1])
		);
	end

	// stage 6: numerator and divisor
	logic [SQW-1:0]      dd_q6;
	logic signed [SQW:0] b_q6;
	rgp_flags_t          fl_q6, fl6_w;
	logic signed [DENW-1:0] den_w;
	logic [NUMW-1:0]     num_w;
	logic                bad_w;

	assign {dd_q6, b_q6, fl_q6} = sside[NQ];

	assign den_w = fl_q6.conc ? DENW'({1'b0, r_q})
	                          : ($signed(DENW'({1'b0, sroot[NQ]})) - DENW'(b_q6));
	assign num_w = fl_q6.conc ? NUMW'(sroot[NQ]) : NUMW'({dd_q6, {TF{1'b0}}});
	assign bad_w = fl_q6.transp || fl_q6.zero
		|| (!fl_q6.conc && (den_w[DENW-1] || (den_w == '0)));

	always_comb begin
		fl6_w      = fl_q6;
		fl6_w.zero = fl_q6.zero || bad_w;
	end

	logic [NUMW-1:0] num_s6;
	logic [DENU-1:0] den_s6;
	rgp_flags_t      fl_s6;
	logic            v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s6 <= bad_w ? '0 : num_w;
			den_s6 <= bad_w ? DENU'(1) : den_w[DENU-1:0];
			fl_s6  <= fl6_w;
		end
	end

	// stage 7: overflow check against den * 2^24
	rgp_flags_t      fl7_w;
	logic [XW-1:0]   num_s7;
	logic [DENU-1:0] den_s7;
	rgp_flags_t      fl_s7;
	logic            v_s7;

	always_comb begin
		fl7_w      = fl_s6;
		fl7_w.over = (XW'(num_s6) >= (XW'(den_s6) << T_OUT_BITS));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s7 <= XW'(num_s6);
			den_s7 <= den_s6;
			fl_s7  <= fl7_w;
		end
	end

	// divider cell row
	logic [XW-1:0]         drem [0:T_OUT_BITS];
	logic [DENU-1:0]       dden [0:T_OUT_BITS];
	logic [T_OUT_BITS-1:0] dq   [0:T_OUT_BITS];
	rgp_flags_t            dfl  [0:T_OUT_BITS];
	logic [T_OUT_BITS:0]   dv;

	assign drem[0] = num_s7;
	assign dden[0] = den_s7;
	assign dq[0]   = '0;
	assign dfl[0]  = fl_s7;
	assign dv[0]   = v_s7;

	for (genvar k = 0; k < T_OUT_BITS; k++) begin : g_div
		rgp_div_cell #(.XW(XW), .DENU(DENU), .K(T_OUT_BITS - 1 - k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.v_i     (dv[k]),
			.rem_i   (drem[k]),
			.den_i   (dden[k]),
			.q_i     (dq[k]),
			.flags_i (dfl[k]),
			.v_o     (dv[k+1]),
			.rem_o   (drem[k+1]),
			.den_o   (dden[k+1]),
			.q_o     (dq[k+1]),
			.flags_o (dfl[k+1])
		);
	end

	// output register
	rgp_flags_t            flo;
	logic [T_OUT_BITS-1:0] grad_q;
	logic                  transp_q, sat_q, vout_q;

	assign flo = dfl[T_OUT_BITS];

	always_ff @(posedge clk) begin
		if (adv) begin
			grad_q   <= (flo.transp || flo.zero) ? '0 : (flo.over ? '1 : dq[T_OUT_BITS]);
			transp_q <= flo.transp;
			sat_q    <= !flo.transp && !flo.zero && flo.over;
		end
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			vout_q <= 1'b0;
		end else if (adv) begin
			v_s1   <= s_tvalid;
			v_s2   <= v_s1;
			v_s5   <= v_s4;
			v_s6   <= sv[NQ];
			v_s7   <= v_s6;
			vout_q <= dv[T_OUT_BITS];
		end
	end

	assign m_tvalid = vout_q;
	assign m_tdata  = grad_q;
	assign m_tuser  = {sat_q, transp_q};

	// checks
	a_transp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
		else $error("transparent result carries a value");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (&m_tdata))
		else $error("saturated result not at maximum");

	a_mul_align: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 == v2_s4) && (!v_s4 || (cneg_s4 == cneg2_s4)))
		else $error("multiplier lanes out of step");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && v_s7 |=> v_s7)
		else $error("stage lost an item during a stall");

endmodule

`default_nettype wire

// ===== sv/rgp_wmul.sv =====
`default_nettype none

// two-stage unsigned multiplier split into four half-width partial products
module rgp_wmul import rgp_pkg::*; #(
	parameter int W  = 50,
	parameter int SW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_i,
	input  wire logic [W-1:0]    a,
	input  wire logic [W-1:0]    b,
	input  wire logic [SW-1:0]   side_i,
	output logic                 v_o,
	output logic [2*W-1:0]       p,
	output logic [SW-1:0]        side_o
);

	localparam int H  = (W + 1) / 2;
	localparam int HH = W - H;

	logic [2*H-1:0]    pll_s1;
	logic [H+HH-1:0]   plh_s1;
	logic [H+HH-1:0]   phl_s1;
	logic [2*HH-1:0]   phh_s1;
	logic [SW-1:0]     side_s1;
	logic              v_s1;
	logic [2*W-1:0]    sum;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1  <= a[H-1:0] * b[H-1:0];
			plh_s1  <= a[H-1:0] * b[W-1:H];
			phl_s1  <= a[W-1:H] * b[H-1:0];
			phh_s1  <= a[W-1:H] * b[W-1:H];
			side_s1 <= side_i;
		end
	end

	// recombine
	assign sum = ((2*W)'(phh_s1) << (2*H))
		+ (((2*W)'(plh_s1) + (2*W)'(phl_s1)) << H)
		+ (2*W)'(pll_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			p      <= sum;
			side_o <= side_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_o  <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_o  <= v_s1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rgp_sqrt_cell.sv =====
`default_nettype none

// one root bit of a restoring square root
module rgp_sqrt_cell import rgp_pkg::*; #(
	parameter int NQ = 50,
	parameter int RW = 100,
	parameter int SW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_i,
	input  wire logic [NQ+1:0]   rem_i,
	input  wire logic [NQ-1:0]   root_i,
	input  wire logic [RW-1:0]   rad_i,
	input  wire logic [SW-1:0]   side_i,
	output logic                 v_o,
	output logic [NQ+1:0]        rem_o,
	output logic [NQ-1:0]        root_o,
	output logic [RW-1:0]        rad_o,
	output logic [SW-1:0]        side_o
);

	logic [NQ+1:0] rem_w;
	logic [NQ+1:0] trial;
	logic          ge;

	// bring down two radicand bits, try root*4+1
	assign rem_w = {rem_i[NQ-1:0], rad_i[RW-1:RW-2]};
	assign trial = {root_i, 2'b01};
	assign ge    = (rem_w >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? (rem_w - trial) : rem_w;
			root_o <= {root_i[NQ-2:0], ge};
			rad_o  <= {rad_i[RW-3:0], 2'b00};
			side_o <= side_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rgp_div_cell.sv =====
`default_nettype none

// one quotient bit of a restoring divider, weight 2^K
module rgp_div_cell import rgp_pkg::*; #(
	parameter int XW   = 80,
	parameter int DENU = 51,
	parameter int K    = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  v_i,
	input  wire logic [XW-1:0]         rem_i,
	input  wire logic [DENU-1:0]       den_i,
	input  wire logic [T_OUT_BITS-1:0] q_i,
	input  wire rgp_flags_t            flags_i,
	output logic                       v_o,
	output logic [XW-1:0]              rem_o,
	output logic [DENU-1:0]            den_o,
	output logic [T_OUT_BITS-1:0]      q_o,
	output rgp_flags_t                 flags_o
);

	logic [XW-1:0] dsh;
	logic          ge;

	// compare against the shifted divisor
	assign dsh = XW'(den_i) << K;
	assign ge  = (rem_i >= dsh);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o   <= ge ? (rem_i - dsh) : rem_i;
			den_o   <= den_i;
			q_o     <= {q_i[T_OUT_BITS-2:0], ge};
			flags_o <= flags_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

endmodule

`default_nettype wire
